/* hdl/tpp_pkg.sv */
// Shared types and constants for the key-hash transaction output parser.
// Used by tpp_front, tpp_queue, tpp_back and tx_output_p2pkh_parser_unit.
package tpp_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0]  OP_DUP        = 8'h76;
    localparam logic [7:0]  KEY_HASH_OP   = 8'hA9;
    localparam logic [7:0]  PUSH_20       = 8'h14;
    localparam logic [7:0]  OP_EQUALVFY   = 8'h88;
    localparam logic [7:0]  SIG_CHECK_OP  = 8'hAC;
    localparam logic [15:0] SCRIPT_MIN    = 16'd25;
    localparam logic [15:0] HASH_END      = 16'd23;
    localparam logic [15:0] POS_EQUALVFY  = 16'd23;
    localparam logic [15:0] POS_SIG_CHECK = 16'd24;
    localparam logic [15:0] LEN_SHORT     = 16'd4;
    localparam logic [15:0] LEN_LONG      = 16'd8;
    localparam logic [1:0]  CHUNK_LAST    = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PARTIAL = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_VAL_FIRST = 3'd0,
        PH_VAL_REST  = 3'd1,
        PH_TOKEN     = 3'd2,
        PH_LEN_HI    = 3'd3,
        PH_LEN_LO    = 3'd4,
        PH_SCRIPT    = 3'd5
    } t_phase;

    typedef struct packed {
        t_status      status;
        logic [63:0]  amount;
        logic [7:0]   token;
        logic [159:0] hash;
    } t_event;

endpackage

/* hdl/tpp_front.sv */
// Front end: takes one byte per cycle while i_accept is high, tracks the
// field being parsed and pushes one completion event per output (ok,
// partial or invalid). Depends on tpp_pkg.
module tpp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_data,
    output logic            o_push,
    output tpp_pkg::t_event o_event
);
    import tpp_pkg::*;

    t_phase        r_phase, n_phase;
    logic [15:0]   r_pos, n_pos;
    logic          r_long, n_long;
    logic [63:0]   r_acc, n_acc;
    logic [7:0]    r_tok, n_tok;
    logic [15:0]   r_len, n_len;
    logic          r_mm, n_mm;
    logic [159:0]  r_hash, n_hash;
    logic [15:0]   pos_inc;
    logic          done;
    logic          bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VAL_FIRST;
            r_pos   <= '0;
            r_long  <= 1'b0;
            r_mm    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_long  <= n_long;
            r_mm    <= n_mm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_tok  <= n_tok;
        r_len  <= n_len;
        r_hash <= n_hash;
    end

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_long  = r_long;
        n_acc   = r_acc;
        n_tok   = r_tok;
        n_len   = r_len;
        n_mm    = r_mm;
        n_hash  = r_hash;
        pos_inc = r_pos + 16'd1;
        done    = 1'b0;
        bad     = 1'b0;
        o_push  = 1'b0;
        o_event = '0;

        if (i_accept) begin
            case (r_phase)
                PH_VAL_FIRST: begin
                    n_long  = i_data_byte[7];
                    n_acc   = {56'd0, i_data_byte};
                    n_pos   = 16'd1;
                    n_phase = PH_VAL_REST;
                end
                PH_VAL_REST: begin
                    n_acc = {r_acc[55:0], i_data_byte};
                    n_pos = pos_inc;
                    if (pos_inc >= (r_long ? LEN_LONG : LEN_SHORT)) begin
                        n_phase = PH_TOKEN;
                    end
                end
                PH_TOKEN: begin
                    n_tok   = i_data_byte;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len   = {i_data_byte, 8'h00};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len = {r_len[15:8], i_data_byte};
                    n_pos = '0;
                    n_mm  = 1'b0;
                    if (n_len == 16'd0) begin
                        done = 1'b1;
                        bad  = 1'b1;
                    end else begin
                        n_phase = PH_SCRIPT;
                    end
                end
                PH_SCRIPT: begin
                    if (r_pos == 16'd0) begin
                        if (i_data_byte != OP_DUP) n_mm = 1'b1;
                    end else if (r_pos == 16'd1) begin
                        if (i_data_byte != KEY_HASH_OP) n_mm = 1'b1;
                    end else if (r_pos == 16'd2) begin
                        if (i_data_byte != PUSH_20) n_mm = 1'b1;
                    end else if (r_pos < HASH_END) begin
                        n_hash = {r_hash[151:0], i_data_byte};
                    end else if (r_pos == POS_EQUALVFY) begin
                        if (i_data_byte != OP_EQUALVFY) n_mm = 1'b1;
                    end else if (r_pos == POS_SIG_CHECK) begin
                        if (i_data_byte != SIG_CHECK_OP) n_mm = 1'b1;
                    end
                    n_pos = pos_inc;
                    if (pos_inc >= r_len) begin
                        done = 1'b1;
                        bad  = (r_len < SCRIPT_MIN) || n_mm;
                    end
                end
                default: begin
                    n_phase = PH_VAL_FIRST;
                end
            endcase

            if (done) begin
                o_push = 1'b1;
                if (bad) begin
                    o_event.status = ST_INVALID;
                end else begin
                    o_event.status = ST_OK;
                    o_event.amount = r_long ? (64'd0 - r_acc) : r_acc;
                    o_event.token  = r_tok;
                    o_event.hash   = r_hash;
                end
                n_phase = PH_VAL_FIRST;
                n_pos   = '0;
            end else if (i_end_of_data) begin
                o_push         = 1'b1;
                o_event.status = ST_PARTIAL;
                n_phase        = PH_VAL_FIRST;
                n_pos          = '0;
            end
        end
    end

endmodule

/* hdl/tpp_queue.sv */
// Short event queue between the parser front end and the result back end.
// Depends on tpp_pkg.
module tpp_queue #(
    parameter int DEPTH = tpp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tpp_pkg::t_event i_event,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tpp_pkg::t_event o_head
);
    import tpp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_event        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + AW'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/tpp_back.sv */
// Back end: expands each queued event into its results and holds them in
// the output register until taken. Depends on tpp_pkg.
module tpp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  tpp_pkg::t_event i_q_head,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_status,
    output logic [63:0]     o_amount,
    output logic [7:0]      o_token_info,
    output logic [63:0]     o_hash_chunk,
    output logic [1:0]      o_chunk_index,
    output logic            o_last_result
);
    import tpp_pkg::*;

    logic        r_valid;
    logic [1:0]  r_chunk;
    logic [1:0]  r_status;
    logic [63:0] r_amount;
    logic [7:0]  r_token;
    logic [63:0] r_hash_chunk;
    logic [1:0]  r_chunk_index;
    logic        r_last;
    logic        load;
    logic        ev_last;
    logic [63:0] chunk_sel;

    assign load    = !r_valid || !i_stall;
    assign ev_last = (i_q_head.status != ST_OK) || (r_chunk == CHUNK_LAST);
    assign o_q_pop = load && i_q_valid && ev_last;

    always_comb begin
        case (r_chunk)
            2'd0:    chunk_sel = i_q_head.hash[159:96];
            2'd1:    chunk_sel = i_q_head.hash[95:32];
            default: chunk_sel = {32'd0, i_q_head.hash[31:0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_chunk <= '0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_chunk <= ev_last ? 2'd0 : r_chunk + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_status      <= i_q_head.status;
            r_amount      <= i_q_head.amount;
            r_token       <= i_q_head.token;
            r_hash_chunk  <= (i_q_head.status == ST_OK) ? chunk_sel : 64'd0;
            r_chunk_index <= (i_q_head.status == ST_OK) ? r_chunk : 2'd0;
            r_last        <= ev_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_amount      = r_amount;
    assign o_token_info  = r_token;
    assign o_hash_chunk  = r_hash_chunk;
    assign o_chunk_index = r_chunk_index;
    assign o_last_result = r_last;

endmodule

/* hdl/tx_output_p2pkh_parser_unit.sv */
// Key-hash transaction output parser, top level.
// Depends on tpp_pkg, tpp_front, tpp_queue and tpp_back.
//
// Input channel: one byte of a serialized output per item (i_data_byte),
// with i_end_of_data marking the last available byte. Taken at an edge with
// i_valid high and o_stall low. One byte per cycle while o_stall is low.
// Output channel: o_valid / i_stall with status, amount, token info, hash
// chunk, chunk index and last flag. A good key-hash output yields three
// results (chunk 0, 1, 2); a partial or invalid output yields one.
// The event for the byte that completes an output is written to the queue,
// then loaded into the output register. When not stalled, further chunks
// follow one per cycle and throughput is one byte per cycle in and one
// result per cycle out, set by the byte parser and the output register.
// A QUEUE_DEPTH-entry event queue sits between parser and result stage;
// o_stall rises only when it is full, i.e. after the receiver has stalled
// long enough for QUEUE_DEPTH outputs to complete unread.
// Reset (synchronous, active low) returns the parser to the first value
// byte and empties the queue and output register.
module tx_output_p2pkh_parser_unit #(
    parameter int QUEUE_DEPTH = tpp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_amount,
    output logic [7:0]  o_token_info,
    output logic [63:0] o_hash_chunk,
    output logic [1:0]  o_chunk_index,
    output logic        o_last_result
);
    import tpp_pkg::*;

    logic   q_full;
    logic   push;
    t_event ev;
    logic   q_valid;
    logic   q_pop;
    t_event q_head;

    assign o_stall = q_full;

    tpp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (i_valid && !q_full),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .o_push        (push),
        .o_event       (ev)
    );

    tpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (ev),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    tpp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_amount      (o_amount),
        .o_token_info  (o_token_info),
        .o_hash_chunk  (o_hash_chunk),
        .o_chunk_index (o_chunk_index),
        .o_last_result (o_last_result)
    );

endmodule
